### rtl/core/dtc_pkg.sv
// Shared types, constants and the month table of the ordinal date converter.
`default_nettype none

package dtc_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned DAY_W   = 9;
    localparam int unsigned SUM_W   = 14;

    localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd9999;
    localparam logic [DAY_W-1:0]  DAY_LIMIT = 9'd367;
    localparam logic [DAY_W-1:0]  DAY_LEAP  = 9'd366;

    // floor(x / 100) = (x * 5243) >> 19 for x below 16384
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int unsigned RECIP_100_SH = 19;
    // floor(x / 7) = (x * 9363) >> 16 for x below 13000
    localparam logic [13:0] RECIP_7     = 14'd9363;
    localparam int unsigned RECIP_7_SH  = 16;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_YEAR = 2'd1,
        ST_BAD_DAY  = 2'd2,
        ST_NOT_LEAP = 2'd3
    } t_status;

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Days before the first of month m, leap day included from March on.
    function automatic logic [8:0] month_first(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        base = (m < 4'd12) ? MONTH_START[m] : 9'd0;
        return base + ((m >= 4'd2) ? {8'd0, leap} : 9'd0);
    endfunction

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DAY_W-1:0]  day_of_year;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic       is_leap;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [2:0] weekday;
    } t_rsp;

    typedef struct packed {
        logic [YEAR_W-1:0] y;
        logic [YEAR_W-1:0] p;
        logic [DAY_W-1:0]  d;
        logic [6:0]        q_p100;
        logic [4:0]        q_p400;
        logic [7:0]        q_y100;
        logic              yr_bad;
        logic              day_bad;
    } t_s1;

    typedef struct packed {
        t_status          status;
        logic             leap;
        logic [SUM_W-1:0] s;
        logic [DAY_W-1:0] d;
    } t_s2;

    typedef struct packed {
        t_status          status;
        logic             leap;
        logic [SUM_W-1:0] s;
        logic [10:0]      q7;
        logic [3:0]       month;
        logic [DAY_W-1:0] d;
    } t_s3;

endpackage

`default_nettype wire

### rtl/core/dtc_if.sv
// Request and response channel interfaces of the ordinal date converter.
`default_nettype none

interface dtc_req_if;
    logic                          valid;
    logic                          ready;
    logic [dtc_pkg::YEAR_W-1:0]    year;
    logic [dtc_pkg::DAY_W-1:0]     day_of_year;

    modport source (output valid, output year, output day_of_year, input ready);
    modport sink   (input valid, input year, input day_of_year, output ready);
endinterface

interface dtc_rsp_if;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             is_leap;
    logic [3:0]       month;
    logic [4:0]       day_of_month;
    logic [2:0]       weekday;

    modport source (output valid, output status, output is_leap, output month,
                    output day_of_month, output weekday, input ready);
    modport sink   (input valid, input status, input is_leap, input month,
                    input day_of_month, input weekday, output ready);
endinterface

`default_nettype wire

### rtl/core/dtc_year_stage.sv
// Stage 1: range checks and the divisions of the year by 100 and 400.
`default_nettype none

module dtc_year_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire dtc_pkg::t_req i_data,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output dtc_pkg::t_s1       o_data
);

    logic              r_vld;
    dtc_pkg::t_s1      r_data;
    dtc_pkg::t_s1      n_data;
    logic [13:0]       p;
    logic [26:0]       prod_p;
    logic [24:0]       prod_q;
    logic [26:0]       prod_y;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        p      = i_data.year - 14'd1;
        prod_p = 27'(p) * 27'(dtc_pkg::RECIP_100);
        prod_q = 25'(p[13:2]) * 25'(dtc_pkg::RECIP_100);
        prod_y = 27'(i_data.year) * 27'(dtc_pkg::RECIP_100);

        n_data.y       = i_data.year;
        n_data.p       = p;
        n_data.d       = i_data.day_of_year;
        n_data.q_p100  = 7'(prod_p >> dtc_pkg::RECIP_100_SH);
        n_data.q_p400  = 5'(prod_q >> dtc_pkg::RECIP_100_SH);
        n_data.q_y100  = 8'(prod_y >> dtc_pkg::RECIP_100_SH);
        n_data.yr_bad  = (i_data.year == '0) || (i_data.year > dtc_pkg::YEAR_MAX);
        n_data.day_bad = (i_data.day_of_year == '0)
                      || (i_data.day_of_year >= dtc_pkg::DAY_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (i_vld && o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/core/dtc_leap_stage.sv
// Stage 2: leap rule, status code and the day count that feeds the weekday.
`default_nettype none

module dtc_leap_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_vld,
    output logic              o_rdy,
    input  wire dtc_pkg::t_s1 i_data,
    output logic              o_vld,
    input  wire logic         i_rdy,
    output dtc_pkg::t_s2      o_data
);

    localparam logic [14:0] HUNDRED = 15'd100;

    logic              r_vld;
    dtc_pkg::t_s2      r_data;
    dtc_pkg::t_s2      n_data;
    logic [14:0]       y_hund;
    logic              cent;
    logic              leap;
    logic [14:0]       sum;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        y_hund = 15'(i_data.q_y100) * HUNDRED;
        cent   = (15'(i_data.y) == y_hund);
        leap   = (i_data.y[1:0] == 2'd0) && (!cent || (i_data.q_y100[1:0] == 2'd0));
        // 365 is 1 mod 7, so whole years add one weekday each
        sum    = 15'(i_data.p) + 15'(i_data.p[13:2]) + 15'(i_data.q_p400)
               + 15'(i_data.d) - 15'(i_data.q_p100) - 15'd1;

        if (i_data.yr_bad) begin
            n_data.status = dtc_pkg::ST_BAD_YEAR;
        end else if (i_data.day_bad) begin
            n_data.status = dtc_pkg::ST_BAD_DAY;
        end else if (!leap && (i_data.d == dtc_pkg::DAY_LEAP)) begin
            n_data.status = dtc_pkg::ST_NOT_LEAP;
        end else begin
            n_data.status = dtc_pkg::ST_OK;
        end
        n_data.leap = leap;
        n_data.s    = sum[13:0];
        n_data.d    = i_data.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (i_vld && o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/core/dtc_month_stage.sv
// Stage 3: month search against the month table and the quotient by seven.
`default_nettype none

module dtc_month_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_vld,
    output logic              o_rdy,
    input  wire dtc_pkg::t_s2 i_data,
    output logic              o_vld,
    input  wire logic         i_rdy,
    output dtc_pkg::t_s3      o_data
);

    logic              r_vld;
    dtc_pkg::t_s3      r_data;
    dtc_pkg::t_s3      n_data;
    logic [27:0]       prod_7;
    logic [3:0]        cnt;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        prod_7 = 28'(i_data.s) * 28'(dtc_pkg::RECIP_7);
        // month index is the number of month starts already passed
        cnt = 4'd0;
        for (int m = 1; m < 12; m++) begin
            cnt = cnt + {3'd0, (i_data.d > dtc_pkg::month_first(4'(m), i_data.leap))};
        end

        n_data.status = i_data.status;
        n_data.leap   = i_data.leap;
        n_data.s      = i_data.s;
        n_data.q7     = 11'(prod_7 >> dtc_pkg::RECIP_7_SH);
        n_data.month  = cnt;
        n_data.d      = i_data.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (i_vld && o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/core/dtc_out_stage.sv
// Stage 4: weekday remainder, day of month and the output register.
`default_nettype none

module dtc_out_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_vld,
    output logic              o_rdy,
    input  wire dtc_pkg::t_s3 i_data,
    output logic              o_vld,
    input  wire logic         i_rdy,
    output dtc_pkg::t_rsp     o_data
);

    localparam logic [13:0] SEVEN = 14'd7;

    logic              r_vld;
    dtc_pkg::t_rsp     r_data;
    dtc_pkg::t_rsp     n_data;
    logic [13:0]       mul7;
    logic [13:0]       rem;
    logic [8:0]        dom;
    logic              ok;

    assign o_rdy = !r_vld || i_rdy;

    always_comb begin
        mul7 = 14'(i_data.q7) * SEVEN;
        rem  = i_data.s - mul7;
        dom  = i_data.d - dtc_pkg::month_first(i_data.month, i_data.leap);
        ok   = (i_data.status == dtc_pkg::ST_OK);

        // zero every field but the status on error
        n_data.status       = i_data.status;
        n_data.is_leap      = ok && i_data.leap;
        n_data.month        = ok ? i_data.month : 4'd0;
        n_data.day_of_month = ok ? dom[4:0] : 5'd0;
        n_data.weekday      = ok ? rem[2:0] : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
        if (i_vld && o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/core/ordinal_date_to_calendar_weekday_unit.sv
// Converts a Gregorian year and day of year to month, day of month and weekday.
//
// Requests arrive on i_req (year, day_of_year); each gives exactly one response
// on o_rsp (status, is_leap, month, day_of_month, weekday, Monday = 0).
// Both channels move a request when valid and ready are high at a rising edge.
// The datapath is a four stage pipeline: range checks and divisions by 100,
// leap rule and day count, month search and quotient by seven, then the
// remainder and day of month into the output register.
// o_rsp.valid rises once a request has passed the year, leap, month and output
// stage registers; one request is accepted every cycle while the response side
// keeps up.
// A stalled o_rsp holds its response; each stage holds its contents and keeps
// taking requests until it is full, so i_req.ready drops only once all four
// stages are occupied.
// A synchronous active-low reset empties the pipeline; no request is lost or
// repeated across a stall.
`default_nettype none

module ordinal_date_to_calendar_weekday_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtc_req_if.sink   i_req,
    dtc_rsp_if.source o_rsp
);

    dtc_pkg::t_req  req;
    dtc_pkg::t_s1   s1_data;
    dtc_pkg::t_s2   s2_data;
    dtc_pkg::t_s3   s3_data;
    dtc_pkg::t_rsp  rsp;
    logic           s1_vld, s1_rdy;
    logic           s2_vld, s2_rdy;
    logic           s3_vld, s3_rdy;

    assign req.year        = i_req.year;
    assign req.day_of_year = i_req.day_of_year;

    dtc_year_stage u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_req.valid),
        .o_rdy   (i_req.ready),
        .i_data  (req),
        .o_vld   (s1_vld),
        .i_rdy   (s1_rdy),
        .o_data  (s1_data)
    );

    dtc_leap_stage u_leap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s1_vld),
        .o_rdy   (s1_rdy),
        .i_data  (s1_data),
        .o_vld   (s2_vld),
        .i_rdy   (s2_rdy),
        .o_data  (s2_data)
    );

    dtc_month_stage u_month (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s2_vld),
        .o_rdy   (s2_rdy),
        .i_data  (s2_data),
        .o_vld   (s3_vld),
        .i_rdy   (s3_rdy),
        .o_data  (s3_data)
    );

    dtc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s3_vld),
        .o_rdy   (s3_rdy),
        .i_data  (s3_data),
        .o_vld   (o_rsp.valid),
        .i_rdy   (o_rsp.ready),
        .o_data  (rsp)
    );

    assign o_rsp.status       = rsp.status;
    assign o_rsp.is_leap      = rsp.is_leap;
    assign o_rsp.month        = rsp.month;
    assign o_rsp.day_of_month = rsp.day_of_month;
    assign o_rsp.weekday      = rsp.weekday;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> s1_vld)
        else $error("accepted request did not enter the first stage");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != dtc_pkg::ST_OK)) |->
        (!o_rsp.is_leap && (o_rsp.month == 4'd0) && (o_rsp.day_of_month == 5'd0)
         && (o_rsp.weekday == 3'd0)))
        else $error("error response carries nonzero fields");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == dtc_pkg::ST_OK)) |->
        ((o_rsp.month <= 4'd11) && (o_rsp.day_of_month != 5'd0)
         && (o_rsp.weekday <= 3'd6)))
        else $error("good response out of calendar range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_req.ready) |-> (s1_vld && s2_vld && s3_vld && o_rsp.valid && !o_rsp.ready))
        else $error("request side stalled with room in the pipeline");

endmodule

`default_nettype wire
